// File: sv/ppts_pkg.sv
// Package for the periodic priority task scheduler.
// Holds the shared types, codes and default sizes; depends on nothing.
package ppts_pkg;

   localparam int MAX_TASKS_DEF = 8;
   localparam int ID_W          = 16;
   localparam int SLOT_OUT_W    = 6;

   typedef enum logic [1:0] {
      MODE_TICK     = 2'd0,
      MODE_CREATE   = 2'd1,
      MODE_DELETE   = 2'd2,
      MODE_DISPATCH = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_EMPTY   = 2'd0,
      ST_READY   = 2'd1,
      ST_WAITING = 2'd2,
      ST_DELETED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      RC_OK         = 2'd0,
      RC_FULL       = 2'd1,
      RC_NOT_FOUND  = 2'd2,
      RC_NONE_READY = 2'd3
   } rcode_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_WALK,
      FSM_DONE
   } fsm_type;

   typedef struct packed {
      logic [ID_W-1:0] id;
      logic [15:0]     period;
      logic [15:0]     prio;
      logic [15:0]     countdown;
      status_type      status;
   } slot_rec_type;

endpackage

// File: sv/ppts_cell.sv
// One slot cell of the scheduler ring.
// Depends on ppts_pkg for the slot record type.
module ppts_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  shift_en,
   input  ppts_pkg::slot_rec_type rec_in,
   output ppts_pkg::slot_rec_type rec_out
);
   import ppts_pkg::*;

   slot_rec_type data_ff;
   status_type   status_ff;

   // The data fields need no reset; only the status starts out empty.
   always_ff @(posedge clock) begin
      if (shift_en) begin
         data_ff <= rec_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= ST_EMPTY;
      end else if (shift_en) begin
         status_ff <= rec_in.status;
      end
   end

   always_comb begin
      rec_out        = data_ff;
      rec_out.status = status_ff;
   end

endmodule

// File: sv/periodic_priority_task_scheduler_core.sv
// Top level of the periodic priority task scheduler.
// Depends on ppts_pkg and ppts_cell (the ring of slot cells).
//
//   Channel | Direction | Handshake           | Payload
//   req     | in        | req_valid/req_stall | mode, period, priority_req, task_id
//   rsp     | out       | rsp_valid/rsp_stall | chosen_id, chosen_slot, result_code
//
// Every command walks the whole ring once and then registers the result; dispatch
// walks it twice (search, then mark). The block is back in idle as the result is
// registered and takes the next transfer in the cycle after that. While a walk runs,
// the ring of cells rotates by one slot per cycle past a single head processor.
// Reset is synchronous and marks every slot empty with the fill count at zero.
// A new request is taken while an earlier response still waits in the output register;
// the finished walk then holds until that response has left.
module periodic_priority_task_scheduler_core #(
   parameter int MAX_TASKS = ppts_pkg::MAX_TASKS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  ppts_pkg::mode_type                  req_mode,
   input  logic [15:0]                         req_period,
   input  logic [15:0]                         req_priority_req,
   input  logic [ppts_pkg::ID_W-1:0]           req_task_id,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ppts_pkg::ID_W-1:0]           rsp_chosen_id,
   output logic [ppts_pkg::SLOT_OUT_W-1:0]     rsp_chosen_slot,
   output ppts_pkg::rcode_type                 rsp_result_code
);
   import ppts_pkg::*;

   localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int FW = $clog2(MAX_TASKS + 1);

   // The ring: cell 0 is the head; the processed head record enters the tail.
   slot_rec_type ring_out [MAX_TASKS];
   slot_rec_type new_rec;
   logic         shift_en;

   genvar g;
   generate
      for (g = 0; g < MAX_TASKS; g++) begin : g_cell
         slot_rec_type link;
         if (g == MAX_TASKS - 1) begin : g_tail
            assign link = new_rec;
         end else begin : g_mid
            assign link = ring_out[g+1];
         end
         ppts_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (shift_en),
            .rec_in   (link),
            .rec_out  (ring_out[g])
         );
      end
   endgenerate

   fsm_type           state_ff, state_in;
   logic [SW-1:0]     step_ff, step_in;
   logic              pass2_ff, pass2_in;
   logic [FW-1:0]     fill_ff, fill_in;
   mode_type          mode_ff;
   logic [15:0]       period_ff, prio_ff;
   logic [ID_W-1:0]   id_ff;
   logic              found_ff, found_in;
   logic              have_ff, have_in;
   logic [SW-1:0]     best_ff, best_in;
   logic [15:0]       best_prio_ff, best_prio_in;
   logic [ID_W-1:0]   best_id_ff, best_id_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]   rsp_id_ff, rsp_id_in;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff, rsp_slot_in;
   rcode_type         rsp_code_ff, rsp_code_in;

   logic          accept;
   logic          used;
   logic          last_step;
   logic          table_full;
   slot_rec_type  head;
   logic [15:0]   cd_dec;

   assign accept     = req_valid && !req_stall;
   assign head       = ring_out[0];
   assign used       = FW'(step_ff) < fill_ff;
   assign last_step  = step_ff == SW'(MAX_TASKS - 1);
   assign table_full = fill_ff >= FW'(MAX_TASKS);
   assign cd_dec     = head.countdown - 16'd1;
   assign shift_en   = state_ff == FSM_WALK;

   // Head processor: the slot at the head is slot number step_ff.
   always_comb begin
      new_rec      = head;
      found_in     = found_ff;
      have_in      = have_ff;
      best_in      = best_ff;
      best_prio_in = best_prio_ff;
      best_id_in   = best_id_ff;
      unique case (mode_ff)
         MODE_TICK: begin
            if (used && head.status == ST_WAITING) begin
               if (cd_dec == 16'd0) begin
                  new_rec.status    = ST_READY;
                  new_rec.countdown = head.period;
               end else begin
                  new_rec.countdown = cd_dec;
               end
            end
         end
         MODE_CREATE: begin
            if (!table_full && FW'(step_ff) == fill_ff) begin
               new_rec.id        = id_ff;
               new_rec.period    = period_ff;
               new_rec.prio      = prio_ff;
               new_rec.countdown = period_ff;
               new_rec.status    = ST_READY;
            end
         end
         MODE_DELETE: begin
            if (used && !found_ff && head.id == id_ff) begin
               new_rec.status = ST_DELETED;
               found_in       = 1'b1;
            end
         end
         MODE_DISPATCH: begin
            if (!pass2_ff) begin
               // Search pass: a later slot wins a priority tie.
               if (used && head.status == ST_READY &&
                   (!have_ff || head.prio >= best_prio_ff)) begin
                  have_in      = 1'b1;
                  best_in      = step_ff;
                  best_prio_in = head.prio;
                  best_id_in   = head.id;
               end
            end else if (have_ff && step_ff == best_ff) begin
               new_rec.status = ST_WAITING;
            end
         end
         default: ;
      endcase
   end

   // Sequencer and response register.
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      pass2_in     = pass2_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_id_in    = rsp_id_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_code_in  = rsp_code_ff;
      req_stall    = state_ff != FSM_IDLE;
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_valid) begin
               state_in = FSM_WALK;
               step_in  = '0;
               pass2_in = 1'b0;
            end
         end
         FSM_WALK: begin
            if (last_step) begin
               step_in = '0;
               if (mode_ff == MODE_DISPATCH && !pass2_ff) begin
                  pass2_in = 1'b1;
               end else begin
                  state_in = FSM_DONE;
               end
            end else begin
               step_in = step_ff + SW'(1);
            end
         end
         FSM_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in     = FSM_IDLE;
               rsp_valid_in = 1'b1;
               rsp_id_in    = '0;
               rsp_slot_in  = '0;
               rsp_code_in  = RC_OK;
               unique case (mode_ff)
                  MODE_TICK: ;
                  MODE_CREATE: begin
                     if (table_full) begin
                        rsp_code_in = RC_FULL;
                     end else begin
                        rsp_slot_in = SLOT_OUT_W'(fill_ff);
                        fill_in     = fill_ff + FW'(1);
                     end
                  end
                  MODE_DELETE: begin
                     if (!found_ff) begin
                        rsp_code_in = RC_NOT_FOUND;
                     end
                  end
                  MODE_DISPATCH: begin
                     if (have_ff) begin
                        rsp_id_in   = best_id_ff;
                        rsp_slot_in = SLOT_OUT_W'(best_ff);
                     end else begin
                        rsp_code_in = RC_NONE_READY;
                     end
                  end
                  default: ;
               endcase
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
         pass2_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         pass2_ff     <= pass2_in;
      end
   end

   // Item registers and per-walk search state.
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff   <= req_mode;
         period_ff <= req_period;
         prio_ff   <= req_priority_req;
         id_ff     <= req_task_id;
         found_ff  <= 1'b0;
         have_ff   <= 1'b0;
      end else if (shift_en) begin
         found_ff  <= found_in;
         have_ff   <= have_in;
      end
      if (shift_en) begin
         best_ff      <= best_in;
         best_prio_ff <= best_prio_in;
         best_id_ff   <= best_id_in;
      end
      rsp_id_ff   <= rsp_id_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_code_ff <= rsp_code_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_chosen_id   = rsp_id_ff;
   assign rsp_chosen_slot = rsp_slot_ff;
   assign rsp_result_code = rsp_code_ff;

endmodule
